FILE: sv/igb_pkg.sv
package igb_pkg;

  // Widths fixed by the item format.
  localparam int FIELD_W   = 16;
  localparam int OUT_W     = 26;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int SEL_W     = 2;
  localparam int K_W       = 30;
  localparam int N_AXES    = 3;
  localparam int N_LANES   = 6;

  // Sensitivities in units of 2^-40 per LSB at the smallest range.
  localparam logic [K_W-1:0] GYRO_Q40  = K_W'(167913358);
  localparam logic [K_W-1:0] ACCEL_Q40 = K_W'(657734068);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_COUNT  = 2'd2;

  // Register values after reset.
  localparam logic [SEL_W-1:0] ACCEL_RANGE_RST = 2'd1;
  localparam logic [SEL_W-1:0] GYRO_RANGE_RST  = 2'd0;
  localparam logic [CNT_W-1:0] BIAS_COUNT_RST  = 16'd200;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_OUT,
    ST_DSTART,
    ST_DIV
  } igb_state_t;

endpackage

FILE: sv/igb_in_if.sv
interface igb_in_if import igb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] gyro_x_raw;
  logic signed [FIELD_W-1:0] gyro_y_raw;
  logic signed [FIELD_W-1:0] gyro_z_raw;
  logic signed [FIELD_W-1:0] accel_x_raw;
  logic signed [FIELD_W-1:0] accel_y_raw;
  logic signed [FIELD_W-1:0] accel_z_raw;

  modport source (
    output valid, gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output accel_x_raw, accel_y_raw, accel_z_raw,
    input  ready
  );

  modport sink (
    input  valid, gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  accel_x_raw, accel_y_raw, accel_z_raw,
    output ready
  );
endinterface

FILE: sv/igb_out_if.sv
interface igb_out_if import igb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] ang_vel_x;
  logic signed [OUT_W-1:0] ang_vel_y;
  logic signed [OUT_W-1:0] ang_vel_z;
  logic signed [OUT_W-1:0] lin_acc_x;
  logic signed [OUT_W-1:0] lin_acc_y;
  logic signed [OUT_W-1:0] lin_acc_z;

  modport source (
    output valid, ang_vel_x, ang_vel_y, ang_vel_z,
    output lin_acc_x, lin_acc_y, lin_acc_z,
    input  ready
  );

  modport sink (
    input  valid, ang_vel_x, ang_vel_y, ang_vel_z,
    input  lin_acc_x, lin_acc_y, lin_acc_z,
    output ready
  );
endinterface

FILE: sv/imu_gyro_bias_calibrate_and_scale.sv
// Channel   Direction  Handshake          Payload
// in_if     sink       valid/ready beat   gyro_x/y/z_raw, accel_x/y/z_raw (16 bit signed)
// out_if    source     valid/ready beat   ang_vel_x/y/z, lin_acc_x/y/z (26 bit signed)
// cfg_*     write      cfg_we per edge    cfg_index selects register, cfg_data carries value
//
// During calibration each beat is taken, adds its gyro samples to the sums and produces
// nothing. The beat that closes calibration starts the three bias dividers; no further beat
// is taken until they are done and the biases are loaded (ST_DSTART, then ST_DIV).
// After calibration a beat is accepted into the operand registers, multiplied in the six
// lanes (ST_MUL), then rounded, saturated and loaded into the output register (ST_OUT).
// The output register lets a new beat be accepted while a result still waits downstream.
// Reset is synchronous and active low; it restores the register defaults and restarts
// calibration.
module imu_gyro_bias_calibrate_and_scale import igb_pkg::*; #(
  parameter int RAW_WIDTH     = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  igb_in_if.sink               in_if,
  igb_out_if.source            out_if
);

  // Gyro sums hold up to 65535 samples, the bias is a Q.8 value of the sample width,
  // and a gyro lane operand is a bias-corrected sample in Q.8 (an accel operand is the plain sample).
  localparam int SUMW = RAW_WIDTH + CNT_W;
  localparam int NW   = SUMW + 8;
  localparam int BW   = RAW_WIDTH + 8;
  localparam int AW   = RAW_WIDTH + 9;

  // Configuration registers.
  logic [SEL_W-1:0] accel_sel_r, accel_sel_nxt;
  logic [SEL_W-1:0] gyro_sel_r, gyro_sel_nxt;
  logic [CNT_W-1:0] bias_cnt_r, bias_cnt_nxt;

  // Control and calibration state.
  igb_state_t          state_r, state_nxt;
  logic                calib_done_r, calib_done_nxt;
  logic [CNT_W-1:0]    calib_cnt_r, calib_cnt_nxt;
  logic signed [SUMW-1:0] sum_r [N_AXES];
  logic signed [SUMW-1:0] sum_nxt [N_AXES];
  logic signed [BW-1:0]   bias_r [N_AXES];
  logic signed [BW-1:0]   bias_nxt [N_AXES];

  // Lane operands and results.
  logic signed [AW-1:0]    op_r [N_LANES];
  logic signed [AW-1:0]    op_nxt [N_LANES];
  logic signed [RAW_WIDTH-1:0] raw [N_LANES];
  logic signed [OUT_W-1:0] lane_res [N_LANES];
  logic signed [OUT_W-1:0] res_r [N_LANES];
  logic                    out_valid_r, out_valid_nxt;
  logic                    load_out;
  logic                    mul_en;

  // Divider hand-over.
  logic                    div_start;
  logic [CNT_W-1:0]        div_den;
  logic signed [BW-1:0]    div_quo [N_AXES];
  logic [N_AXES-1:0]       div_done;

  logic                    in_beat;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    calib_last;

  assign raw[0] = in_if.gyro_x_raw[RAW_WIDTH-1:0];
  assign raw[1] = in_if.gyro_y_raw[RAW_WIDTH-1:0];
  assign raw[2] = in_if.gyro_z_raw[RAW_WIDTH-1:0];
  assign raw[3] = in_if.accel_x_raw[RAW_WIDTH-1:0];
  assign raw[4] = in_if.accel_y_raw[RAW_WIDTH-1:0];
  assign raw[5] = in_if.accel_z_raw[RAW_WIDTH-1:0];

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_beat     = in_if.valid && in_if.ready;

  // A zero count behaves as one; the counter wrapping to zero also ends calibration.
  assign div_den    = (bias_cnt_r == '0) ? CNT_W'(1) : bias_cnt_r;
  assign cnt_inc    = calib_cnt_r + CNT_W'(1);
  assign calib_last = (cnt_inc >= div_den) || (cnt_inc == '0);

  assign div_start = (state_r == ST_DSTART);
  assign mul_en    = (state_r == ST_MUL);
  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || out_if.ready);

  // Configuration writes.
  always_comb begin
    accel_sel_nxt = accel_sel_r;
    gyro_sel_nxt  = gyro_sel_r;
    bias_cnt_nxt  = bias_cnt_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_RANGE: accel_sel_nxt = cfg_data[SEL_W-1:0];
        CFG_GYRO_RANGE:  gyro_sel_nxt  = cfg_data[SEL_W-1:0];
        CFG_BIAS_COUNT:  bias_cnt_nxt  = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: calibration accumulation, bias division and the scaling pass.
  always_comb begin
    state_nxt      = state_r;
    calib_done_nxt = calib_done_r;
    calib_cnt_nxt  = calib_cnt_r;
    out_valid_nxt  = out_valid_r;
    for (int i = 0; i < N_AXES; i++) begin
      sum_nxt[i]  = sum_r[i];
      bias_nxt[i] = bias_r[i];
    end
    for (int i = 0; i < N_LANES; i++) begin
      op_nxt[i] = op_r[i];
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (!calib_done_r) begin
            for (int i = 0; i < N_AXES; i++) begin
              sum_nxt[i] = sum_r[i] + SUMW'(raw[i]);
            end
            calib_cnt_nxt = cnt_inc;
            if (calib_last) begin
              state_nxt = ST_DSTART;
            end
          end else begin
            // Gyro operand is the Q.8 sample less its bias; accel operand is the sample.
            for (int i = 0; i < N_AXES; i++) begin
              op_nxt[i] = (AW'(raw[i]) <<< 8) - AW'(bias_r[i]);
            end
            for (int i = N_AXES; i < N_LANES; i++) begin
              op_nxt[i] = AW'(raw[i]);
            end
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DSTART: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (&div_done) begin
          for (int i = 0; i < N_AXES; i++) begin
            bias_nxt[i] = div_quo[i];
          end
          calib_done_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_sel_r  <= ACCEL_RANGE_RST;
      gyro_sel_r   <= GYRO_RANGE_RST;
      bias_cnt_r   <= BIAS_COUNT_RST;
      state_r      <= ST_IDLE;
      calib_done_r <= 1'b0;
      calib_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < N_AXES; i++) begin
        sum_r[i]  <= '0;
        bias_r[i] <= '0;
      end
    end else begin
      accel_sel_r  <= accel_sel_nxt;
      gyro_sel_r   <= gyro_sel_nxt;
      bias_cnt_r   <= bias_cnt_nxt;
      state_r      <= state_nxt;
      calib_done_r <= calib_done_nxt;
      calib_cnt_r  <= calib_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      for (int i = 0; i < N_AXES; i++) begin
        sum_r[i]  <= sum_nxt[i];
        bias_r[i] <= bias_nxt[i];
      end
    end
    for (int i = 0; i < N_LANES; i++) begin
      op_r[i] <= op_nxt[i];
      if (load_out) begin
        res_r[i] <= lane_res[i];
      end
    end
  end

  // Three bias dividers, one per gyro axis, running side by side.
  for (genvar g = 0; g < N_AXES; g++) begin : g_div
    igb_div #(
      .NW (NW),
      .QW (BW)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (div_start),
      .num   ({sum_r[g], 8'b0}),
      .den   (div_den),
      .quo   (div_quo[g]),
      .done  (div_done[g])
    );
  end

  // Six scaling lanes: three gyro axes, then three accelerometer axes.
  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    if (g < N_AXES) begin : g_gyro
      igb_lane #(
        .AW (AW),
        .S  (48 - OUT_FRAC_BITS),
        .K  (GYRO_Q40)
      ) u_lane (
        .clk    (clk),
        .mul_en (mul_en),
        .op     (op_r[g]),
        .sel    (gyro_sel_r),
        .res    (lane_res[g])
      );
    end else begin : g_accel
      igb_lane #(
        .AW (AW),
        .S  (40 - OUT_FRAC_BITS),
        .K  (ACCEL_Q40)
      ) u_lane (
        .clk    (clk),
        .mul_en (mul_en),
        .op     (op_r[g]),
        .sel    (accel_sel_r),
        .res    (lane_res[g])
      );
    end
  end

  // Merge the lane results into the output beat.
  assign out_if.valid     = out_valid_r;
  assign out_if.ang_vel_x = res_r[0];
  assign out_if.ang_vel_y = res_r[1];
  assign out_if.ang_vel_z = res_r[2];
  assign out_if.lin_acc_x = res_r[3];
  assign out_if.lin_acc_y = res_r[4];
  assign out_if.lin_acc_z = res_r[5];

endmodule

FILE: sv/igb_div.sv
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
module igb_div import igb_pkg::*; #(
  parameter int NW = 40,
  parameter int QW = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [CNT_W-1:0]     den,
  output logic signed [QW-1:0] quo,
  output logic                 done
);

  localparam int CW = $clog2(NW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [NW-1:0]     num_r, num_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;
  logic [QW-1:0]     q_mag;

  always_comb begin
    rem_sh   = {rem_r, num_r[NW-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      neg_nxt  = num[NW-1];
      num_nxt  = num[NW-1] ? NW'(-num) : NW'(num);
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], ge};
      rem_nxt = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign q_mag = num_r[QW-1:0];
  assign quo   = neg_r ? $signed(-q_mag) : $signed(q_mag);
  assign done  = done_r;

endmodule

FILE: sv/igb_lane.sv
// One scaling lane: operand times sensitivity, range shift, rounding and saturation.
module igb_lane import igb_pkg::*; #(
  parameter int             AW = 25,
  parameter int             S  = 32,
  parameter logic [K_W-1:0] K  = GYRO_Q40
) (
  input  logic                 clk,
  input  logic                 mul_en,
  input  logic signed [AW-1:0] op,
  input  logic [SEL_W-1:0]     sel,
  output logic signed [OUT_W-1:0] res
);

  localparam int PW = AW + K_W + 1;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] HALF   = SW'(1) <<< (S - 1);
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [SW-1:0] scaled;
  logic signed [SW-1:0] rounded;
  logic signed [SW-1:0] shifted;

  assign prod_nxt = $signed(op) * $signed({1'b0, K});

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    scaled  = SW'(prod_r) <<< sel;
    rounded = scaled + HALF;
    shifted = rounded >>> S;
    if (shifted > SAT_HI) begin
      res = SAT_HI[OUT_W-1:0];
    end else if (shifted < SAT_LO) begin
      res = SAT_LO[OUT_W-1:0];
    end else begin
      res = shifted[OUT_W-1:0];
    end
  end

endmodule
